### hdl/ccm_pkg.sv
// ----------------------------------------------------------------------------
// ccm_pkg
// Shared types and constants of the character class matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package ccm_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int ENT_AW      = $clog2(MAX_ENTRIES);
    localparam int IDX_W       = 4;
    localparam int CNT_W       = 5;
    localparam int BYTE_W      = 8;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 5;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_TEST = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT      = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [IDX_W-1:0]  entry_index;
        logic [BYTE_W-1:0] range_low;
        logic [BYTE_W-1:0] range_high;
        logic [BYTE_W-1:0] text_byte;
        logic              at_end;
    } req_t;

    typedef struct packed {
        logic                   is_test;
        logic                   at_end;
        logic [MAX_ENTRIES-1:0] hits;
    } hit_t;

endpackage

`default_nettype wire

### hdl/ccm_if.sv
// ----------------------------------------------------------------------------
// ccm_req_if / ccm_rsp_if
// Valid/ready channels for request and result beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface ccm_req_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [3:0] entry_index;
    logic [7:0] range_low;
    logic [7:0] range_high;
    logic [7:0] text_byte;
    logic       at_end;

    modport source (output valid, req_type, entry_index, range_low, range_high,
                    text_byte, at_end, input ready);
    modport sink   (input valid, req_type, entry_index, range_low, range_high,
                    text_byte, at_end, output ready);
endinterface

interface ccm_rsp_if;
    logic valid;
    logic ready;
    logic matched;

    modport source (output valid, matched, input ready);
    modport sink   (input valid, matched, output ready);
endinterface

`default_nettype wire

### hdl/ccm_compare_stage.sv
// ----------------------------------------------------------------------------
// ccm_compare_stage
// Class entry store and parallel range comparators; registers the hit vector.
// ----------------------------------------------------------------------------
`default_nettype none

module ccm_compare_stage (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire ccm_pkg::req_t         in_item,
    input  wire logic [ccm_pkg::CNT_W-1:0] entry_count,
    output logic                       in_ready,
    output logic                       out_valid,
    output ccm_pkg::hit_t              out_item,
    input  wire logic                  out_ready
);
    import ccm_pkg::*;

    logic [BYTE_W-1:0]      low_bounds_reg  [MAX_ENTRIES];
    logic [BYTE_W-1:0]      high_bounds_reg [MAX_ENTRIES];
    logic                   valid_reg;
    logic                   valid_next;
    hit_t                   item_reg;
    hit_t                   item_next;
    logic                   advance;
    logic                   load_we;

    assign in_ready  = !valid_reg || out_ready;
    assign advance   = in_valid && in_ready;
    assign load_we   = advance && (in_item.req_type == REQ_LOAD)
                       && (32'(in_item.entry_index) < MAX_ENTRIES);
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_comb
    begin
        item_next.is_test = (in_item.req_type == REQ_TEST);
        item_next.at_end  = in_item.at_end;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            item_next.hits[i] = (CNT_W'(i) < entry_count)
                                && (in_item.text_byte >= low_bounds_reg[i])
                                && (in_item.text_byte <= high_bounds_reg[i]);
        end
        if (advance)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            item_reg <= item_next;
        if (load_we)
        begin
            low_bounds_reg[ENT_AW'(in_item.entry_index)]  <= in_item.range_low;
            high_bounds_reg[ENT_AW'(in_item.entry_index)] <= in_item.range_high;
        end
    end

endmodule

`default_nettype wire

### hdl/ccm_resolve_stage.sv
// ----------------------------------------------------------------------------
// ccm_resolve_stage
// Reduces the hit vector, applies inversion and end of text; output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ccm_resolve_stage (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire ccm_pkg::hit_t in_item,
    input  wire logic          invert,
    output logic               in_ready,
    output logic               out_valid,
    output logic               out_matched,
    input  wire logic          out_ready
);
    import ccm_pkg::*;

    logic valid_reg;
    logic valid_next;
    logic matched_reg;
    logic matched_next;
    logic advance;

    assign in_ready    = !valid_reg || out_ready;
    assign advance     = in_valid && in_ready;
    assign out_valid   = valid_reg;
    assign out_matched = matched_reg;

    always_comb
    begin
        matched_next = in_item.is_test && !in_item.at_end
                       && ((|in_item.hits) ^ invert);
        if (advance)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            matched_reg <= matched_next;
    end

endmodule

`default_nettype wire

### hdl/char_class_matcher_top.sv
// ----------------------------------------------------------------------------
// char_class_matcher_top
// Regex bracket character class matcher.
//
// Channels: req (sink) carries load beats (req_type 0: write entry_index with
// range_low..range_high) and test beats (req_type 1: text_byte, at_end).
// rsp (source) returns one beat per request: matched is 1 when the byte lies
// in one of the first entry_count entries (in none of them when invert is
// set); it is 0 for loads and at end of text.
// Configuration: cfg_we/cfg_index/cfg_wdata write entry_count (index 0) and
// invert (index 1); write them only while no beat is in flight.
// Timing: three register stages (input, compare, resolve). rsp.valid rises
// once a request has passed the input, compare and resolve registers; one
// request enters per cycle while rsp is not stalled, since the sixteen range
// comparators work in parallel in one stage. A load is visible to the very
// next test beat. Reset clears all valid flags, entry_count and invert;
// entries stay undefined until loaded. When rsp stalls, stages fill up and
// req.ready drops once all three hold a beat; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module char_class_matcher_top (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [ccm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [ccm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    ccm_req_if.sink                              req,
    ccm_rsp_if.source                            rsp
);
    import ccm_pkg::*;

    logic [CNT_W-1:0] entry_count_reg;
    logic             invert_reg;
    logic             s1_valid_reg;
    logic             s1_valid_next;
    req_t             s1_item_reg;
    req_t             s1_item_next;
    logic             s1_ready;
    logic             s2_ready;
    logic             s2_valid;
    hit_t             s2_item;
    logic             s3_ready;

    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign req.ready = s1_ready;

    always_comb
    begin
        s1_item_next.req_type    = req.req_type;
        s1_item_next.entry_index = req.entry_index;
        s1_item_next.range_low   = req.range_low;
        s1_item_next.range_high  = req.range_high;
        s1_item_next.text_byte   = req.text_byte;
        s1_item_next.at_end      = req.at_end;
        if (req.valid && s1_ready)
            s1_valid_next = 1'b1;
        else if (s2_ready)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            entry_count_reg <= '0;
            invert_reg      <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_ENTRY_COUNT: entry_count_reg <= CNT_W'(cfg_wdata);
                    CFG_INVERT:      invert_reg      <= cfg_wdata[0];
                    default:         ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && s1_ready)
            s1_item_reg <= s1_item_next;
    end

    ccm_compare_stage u_compare (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s1_valid_reg),
        .in_item     (s1_item_reg),
        .entry_count (entry_count_reg),
        .in_ready    (s2_ready),
        .out_valid   (s2_valid),
        .out_item    (s2_item),
        .out_ready   (s3_ready)
    );

    ccm_resolve_stage u_resolve (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s2_valid),
        .in_item     (s2_item),
        .invert      (invert_reg),
        .in_ready    (s3_ready),
        .out_valid   (rsp.valid),
        .out_matched (rsp.matched),
        .out_ready   (rsp.ready)
    );

endmodule

`default_nettype wire
